// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising clk edge while out of reset.
`define LSM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true while out of reset.
`define LSM_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LSM_ASSERT(lbl, prop, msg)
`define LSM_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/lsm_pkg.sv =====
// Package: constants, command codes and state type of the load/store memory.
`timescale 1ns / 1ps

package lsm_pkg;

    // Data memory size in bytes; a power of two, multiple of 4
    localparam int unsigned MEM_BYTES = 65536;
    localparam int unsigned OFF_W     = $clog2(MEM_BYTES);
    localparam int unsigned ROW_W     = OFF_W - 2;
    localparam int unsigned MEM_ROWS  = MEM_BYTES / 4;

    // Address map
    localparam logic [31:0] MEM_BASE      = 32'h8000_0000;
    localparam logic [31:0] TIMER_LO_ADDR = 32'hA000_0048;
    localparam logic [31:0] TIMER_HI_ADDR = 32'hA000_004C;
    localparam logic [31:0] UART_ADDR     = 32'hA000_03F8;

    // Readiness code that lets an access proceed
    localparam logic [1:0] RDY_OK = 2'd3;

    // Access commands
    localparam logic [3:0] CMD_SW  = 4'd1;
    localparam logic [3:0] CMD_SH  = 4'd2;
    localparam logic [3:0] CMD_SB  = 4'd3;
    localparam logic [3:0] CMD_LB  = 4'd4;
    localparam logic [3:0] CMD_LBU = 4'd5;
    localparam logic [3:0] CMD_LH  = 4'd6;
    localparam logic [3:0] CMD_LHU = 4'd7;
    localparam logic [3:0] CMD_LW  = 4'd8;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WR2,
        ST_LOAD
    } lsm_state_t;

endpackage

// ===== rtl/load_store_memory_with_mmio_top.sv =====
// Top level: RV32 data memory with uptime timer and UART character port.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------------
//  access   | start / busy       | cmd, err_code, ready_code, addr, store_data,
//           |                    | elapsed_us
//  result   | done (1-cycle)     | read_data, uart_valid, uart_char
//
// An item is taken when start is high and busy is low. The item passes through
// EXEC, then LOAD for loads or WR2 for stores that cross a 32-bit row; its
// result is registered onto done as the last of these states ends. Busy drops
// in that same cycle, so a new item can be taken while done is shown. The
// memory is one word-wide array with byte write enables, one write port and
// two read ports; a row-crossing store needs a second write. Reset clears the
// uptime counter and control; memory contents are undefined until written.
// Results cannot be stalled.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module load_store_memory_with_mmio_top
    import lsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  cmd,
    input  logic [1:0]  err_code,
    input  logic [1:0]  ready_code,
    input  logic [31:0] addr,
    input  logic [31:0] store_data,
    input  logic [15:0] elapsed_us,
    output logic        done,
    output logic [31:0] read_data,
    output logic        uart_valid,
    output logic [7:0]  uart_char
);

    lsm_state_t  state_reg, state_next;
    logic [63:0] uptime_reg, uptime_next;

    logic [3:0]  cmd_reg;
    logic [1:0]  err_reg;
    logic [1:0]  rdy_reg;
    logic [31:0] addr_reg;
    logic [31:0] sdata_reg;

    logic        done_reg, done_next;
    logic [31:0] read_data_reg, read_data_next;
    logic        uart_valid_reg, uart_valid_next;
    logic [7:0]  uart_char_reg, uart_char_next;

    logic [31:0] ram_words [MEM_ROWS];
    logic [31:0] rd_lo_reg;
    logic [31:0] rd_hi_reg;

    logic        accept;
    logic        access_ok;
    logic        is_tlo;
    logic        is_thi;
    logic        is_store;
    logic        is_load;
    logic        is_uart;
    logic        mem_store;
    logic        mem_load;
    logic [31:0] off_full;
    logic [ROW_W-1:0] row_lo;
    logic [ROW_W-1:0] row_hi;
    logic [1:0]  lane;
    logic [3:0]  size_mask;
    logic [7:0]  be8;
    logic [63:0] wdata64;
    logic        spans;
    logic [63:0] ld64;
    logic [31:0] ld32;
    logic [31:0] load_value;

    logic        wr_en;
    logic [ROW_W-1:0] wr_row;
    logic [3:0]  wr_be;
    logic [31:0] wr_data;
    logic        rd_en;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Latch the item on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= cmd;
            err_reg   <= err_code;
            rdy_reg   <= ready_code;
            addr_reg  <= addr;
            sdata_reg <= store_data;
        end
    end

    // Uptime advances before the access is served
    always_comb
    begin
        uptime_next = uptime_reg;
        if (accept)
        begin
            uptime_next = uptime_reg + {48'd0, elapsed_us};
        end
    end

    // Decode of the latched item
    assign access_ok = (err_reg == 2'd0) && (rdy_reg == RDY_OK);
    assign is_tlo    = (addr_reg == TIMER_LO_ADDR);
    assign is_thi    = (addr_reg == TIMER_HI_ADDR);
    assign is_uart   = (addr_reg == UART_ADDR);
    assign is_store  = (cmd_reg == CMD_SW) || (cmd_reg == CMD_SH) || (cmd_reg == CMD_SB);
    assign is_load   = (cmd_reg == CMD_LB) || (cmd_reg == CMD_LBU) || (cmd_reg == CMD_LH)
                    || (cmd_reg == CMD_LHU) || (cmd_reg == CMD_LW);
    assign mem_store = access_ok && !is_tlo && !is_thi && is_store && !is_uart;
    assign mem_load  = access_ok && !is_tlo && !is_thi && is_load;

    // Byte offset into the memory, wrapped by truncation
    assign off_full = addr_reg - MEM_BASE;
    assign row_lo   = off_full[OFF_W-1:2];
    assign lane     = off_full[1:0];
    assign row_hi   = row_lo + {{(ROW_W-1){1'b0}}, 1'b1};

    // Store lanes: bytes of the access spread over two rows
    always_comb
    begin
        case (cmd_reg)
            CMD_SW:  size_mask = 4'b1111;
            CMD_SH:  size_mask = 4'b0011;
            default: size_mask = 4'b0001;
        endcase
    end

    assign be8     = {4'b0000, size_mask} << lane;
    assign wdata64 = {32'd0, sdata_reg} << {lane, 3'b000};
    assign spans   = |be8[7:4];

    // Load: align the two rows read and extend
    assign ld64 = {rd_hi_reg, rd_lo_reg} >> {lane, 3'b000};
    assign ld32 = ld64[31:0];

    always_comb
    begin
        case (cmd_reg)
            CMD_LB:  load_value = {{24{ld32[7]}}, ld32[7:0]};
            CMD_LBU: load_value = {24'd0, ld32[7:0]};
            CMD_LH:  load_value = {{16{ld32[15]}}, ld32[15:0]};
            CMD_LHU: load_value = {16'd0, ld32[15:0]};
            default: load_value = ld32;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (mem_store && spans)
                begin
                    state_next = ST_WR2;
                end
                else if (mem_load)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_WR2:  state_next = ST_IDLE;
            ST_LOAD: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs: memory port control and result
    always_comb
    begin
        wr_en           = 1'b0;
        wr_row          = row_lo;
        wr_be           = be8[3:0];
        wr_data         = wdata64[31:0];
        rd_en           = 1'b0;
        done_next       = 1'b0;
        read_data_next  = 32'd0;
        uart_valid_next = 1'b0;
        uart_char_next  = 8'd0;
        case (state_reg)
            ST_EXEC:
            begin
                if (mem_store)
                begin
                    wr_en     = 1'b1;
                    done_next = !spans;
                end
                else if (mem_load)
                begin
                    rd_en = 1'b1;
                end
                else
                begin
                    done_next = 1'b1;
                    if (!access_ok)
                    begin
                        read_data_next = 32'd0;
                    end
                    else if (is_tlo)
                    begin
                        read_data_next = uptime_reg[31:0];
                    end
                    else if (is_thi)
                    begin
                        read_data_next = uptime_reg[63:32];
                    end
                    else if (is_store)
                    begin
                        uart_valid_next = 1'b1;
                        uart_char_next  = sdata_reg[7:0];
                    end
                    else
                    begin
                        read_data_next = addr_reg;
                    end
                end
            end
            ST_WR2:
            begin
                wr_en     = 1'b1;
                wr_row    = row_hi;
                wr_be     = be8[7:4];
                wr_data   = wdata64[63:32];
                done_next = 1'b1;
            end
            ST_LOAD:
            begin
                done_next      = 1'b1;
                read_data_next = load_value;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Data memory: byte-enabled write, two registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                if (wr_be[l])
                begin
                    ram_words[wr_row][l*8 +: 8] <= wr_data[l*8 +: 8];
                end
            end
        end
        if (rd_en)
        begin
            rd_lo_reg <= ram_words[row_lo];
            rd_hi_reg <= ram_words[row_hi];
        end
    end

    // Control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            uptime_reg     <= 64'd0;
            done_reg       <= 1'b0;
            read_data_reg  <= 32'd0;
            uart_valid_reg <= 1'b0;
            uart_char_reg  <= 8'd0;
        end
        else
        begin
            state_reg      <= state_next;
            uptime_reg     <= uptime_next;
            done_reg       <= done_next;
            read_data_reg  <= read_data_next;
            uart_valid_reg <= uart_valid_next;
            uart_char_reg  <= uart_char_next;
        end
    end

    assign done       = done_reg;
    assign read_data  = read_data_reg;
    assign uart_valid = uart_valid_reg;
    assign uart_char  = uart_char_reg;

    // Checks
    `LSM_ASSERT(a_done_single, done |=> !done, "done held for more than one cycle")
    `LSM_ASSERT(a_uart_with_done, uart_valid |-> (done && read_data == 32'd0), "uart without result")
    `LSM_ASSERT(a_wr2_after_exec, (state_reg == ST_WR2) |-> ($past(state_reg) == ST_EXEC), "bad second write")
    `LSM_NEVER(a_no_rw_clash, wr_en && rd_en, "memory read and write in one cycle")
    `LSM_ASSERT(a_accept_busy, accept |=> busy, "busy not raised after accept")

endmodule

// ===== verif/testbench.sv =====
// Testbench for the load/store data memory: directed and random accesses, self-checked.
`timescale 1ns / 1ps

module testbench;
    import lsm_pkg::*;

    // Codes without a name in the package
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [3:0] CMD_NONE      = 4'd0;
    localparam logic [3:0] CMD_PASS_MIN  = 4'd9;
    localparam logic [3:0] CMD_PASS_MAX  = 4'd15;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned TAIL_CYCLES    = 8;

    typedef struct packed {
        logic [31:0] read_data;
        logic        uart_valid;
        logic [7:0]  uart_char;
    } mem_result_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic        busy;
    logic [3:0]  cmd        = '0;
    logic [1:0]  err_code   = '0;
    logic [1:0]  ready_code = '0;
    logic [31:0] addr       = '0;
    logic [31:0] store_data = '0;
    logic [15:0] elapsed_us = '0;
    logic        done;
    logic [31:0] read_data;
    logic        uart_valid;
    logic [7:0]  uart_char;

    // Shadow of the memory contents and the uptime counter
    logic [7:0]  mem_image [MEM_BYTES];
    bit          lane_written [MEM_BYTES];
    logic [63:0] uptime_image = '0;

    mem_result_t expected_results [$];
    int unsigned check_failures = 0;
    int unsigned stall_cycles   = 0;

    load_store_memory_with_mmio_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .err_code   (err_code),
        .ready_code (ready_code),
        .addr       (addr),
        .store_data (store_data),
        .elapsed_us (elapsed_us),
        .done       (done),
        .read_data  (read_data),
        .uart_valid (uart_valid),
        .uart_char  (uart_char)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Number of bytes moved by an access command
    function automatic int unsigned access_bytes(input logic [3:0] c);
        if (c == CMD_SW || c == CMD_LW)
            return 4;
        if (c == CMD_SH || c == CMD_LH || c == CMD_LHU)
            return 2;
        return 1;
    endfunction

    function automatic logic [31:0] byte_offset(input logic [31:0] a);
        logic [31:0] rel;
        rel = a - MEM_BASE;
        return rel % MEM_BYTES;
    endfunction

    function automatic logic [31:0] read_lanes(input logic [31:0] a, input int unsigned n);
        logic [31:0] base;
        logic [31:0] word;
        base = byte_offset(a);
        word = '0;
        for (int unsigned i = 0; i < n; i++)
            word[8*i +: 8] = mem_image[(base + i) % MEM_BYTES];
        return word;
    endfunction

    function automatic void write_lanes(input logic [31:0] a, input logic [31:0] d,
                                        input int unsigned n);
        logic [31:0] base;
        base = byte_offset(a);
        for (int unsigned i = 0; i < n; i++)
        begin
            mem_image[(base + i) % MEM_BYTES]    = d[8*i +: 8];
            lane_written[(base + i) % MEM_BYTES] = 1'b1;
        end
    endfunction

    // True when every byte a load at this address would read has been written
    function automatic bit lanes_defined(input logic [31:0] a, input int unsigned n);
        logic [31:0] base;
        base = byte_offset(a);
        for (int unsigned i = 0; i < n; i++)
            if (!lane_written[(base + i) % MEM_BYTES])
                return 1'b0;
        return 1'b1;
    endfunction

    // Serve one access on the shadow state and return what the memory answers
    function automatic mem_result_t serve_access(input logic [3:0] c, input logic [1:0] e,
                                                 input logic [1:0] r, input logic [31:0] a,
                                                 input logic [31:0] d, input logic [15:0] us);
        mem_result_t res;
        logic [31:0] word;
        res = '0;
        uptime_image = uptime_image + 64'(us);
        if (e == ERR_NONE && r == RDY_OK)
        begin
            if (a == TIMER_LO_ADDR)
                res.read_data = uptime_image[31:0];
            else if (a == TIMER_HI_ADDR)
                res.read_data = uptime_image[63:32];
            else if (c == CMD_SW || c == CMD_SH || c == CMD_SB)
            begin
                if (a == UART_ADDR)
                begin
                    res.uart_valid = 1'b1;
                    res.uart_char  = d[7:0];
                end
                else
                    write_lanes(a, d, access_bytes(c));
            end
            else
            begin
                word = read_lanes(a, access_bytes(c));
                case (c)
                    CMD_LB:  res.read_data = {{24{word[7]}}, word[7:0]};
                    CMD_LBU: res.read_data = {24'd0, word[7:0]};
                    CMD_LH:  res.read_data = {{16{word[15]}}, word[15:0]};
                    CMD_LHU: res.read_data = {16'd0, word[15:0]};
                    CMD_LW:  res.read_data = word;
                    default: res.read_data = a;
                endcase
            end
        end
        return res;
    endfunction

    // Result checker, shadow update on accepted items, and stall watchdog
    always @(posedge clk)
    begin
        mem_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no access outstanding: read_data %h", read_data);
                    check_failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (read_data !== want.read_data)
                    begin
                        $error("read_data: expected %h, got %h", want.read_data, read_data);
                        check_failures++;
                    end
                    if (uart_valid !== want.uart_valid)
                    begin
                        $error("uart_valid: expected %b, got %b", want.uart_valid, uart_valid);
                        check_failures++;
                    end
                    if (uart_char !== want.uart_char)
                    begin
                        $error("uart_char: expected %h, got %h", want.uart_char, uart_char);
                        check_failures++;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(serve_access(cmd, err_code, ready_code, addr,
                                                        store_data, elapsed_us));
            if (done || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // Hold start low with junk on the fields
    task automatic idle_cycles(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
        begin
            start      <= 1'b0;
            cmd        <= 4'($urandom);
            err_code   <= 2'($urandom);
            ready_code <= 2'($urandom);
            addr       <= $urandom;
            store_data <= $urandom;
            elapsed_us <= 16'($urandom);
            @(posedge clk);
        end
    endtask

    // Present one item and return at the edge that takes it
    task automatic send_access(input logic [3:0] c, input logic [1:0] e, input logic [1:0] r,
                               input logic [31:0] a, input logic [31:0] d,
                               input logic [15:0] us);
        start      <= 1'b1;
        cmd        <= c;
        err_code   <= e;
        ready_code <= r;
        addr       <= a;
        store_data <= d;
        elapsed_us <= us;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drop start first so the checker has queued the last item before the queue is read
    task automatic wait_drain();
        idle_cycles(1);
        while (expected_results.size() != 0)
            idle_cycles(1);
    endtask

    // Memory address: mostly a small window, some near the top end, some anywhere,
    // half of them through an alias in the upper address bits
    function automatic logic [31:0] pick_mem_addr();
        logic [31:0] off;
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
            off = $urandom_range(0, 63);
        else if (sel < 9)
            off = MEM_BYTES - 64 + $urandom_range(0, 63);
        else
            off = $urandom % MEM_BYTES;
        if ($urandom_range(0, 1) == 0)
            return MEM_BASE + off;
        return MEM_BASE + off + ($urandom << OFF_W);
    endfunction

    task automatic send_random_access();
        logic [3:0]  c;
        logic [1:0]  e;
        logic [1:0]  r;
        logic [31:0] a;
        logic [31:0] d;
        logic [15:0] us;
        int unsigned pick;
        pick = $urandom_range(1, 100);
        e    = ERR_NONE;
        r    = RDY_OK;
        a    = pick_mem_addr();
        d    = $urandom;
        us   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        if (pick <= 35)
        begin
            case ($urandom_range(0, 2))
                0:       c = CMD_SW;
                1:       c = CMD_SH;
                default: c = CMD_SB;
            endcase
        end
        else if (pick <= 70)
        begin
            case ($urandom_range(0, 4))
                0:       c = CMD_LB;
                1:       c = CMD_LBU;
                2:       c = CMD_LH;
                3:       c = CMD_LHU;
                default: c = CMD_LW;
            endcase
            // fill the word first through its canonical address so no load sees an
            // unwritten byte
            if (!lanes_defined(a, access_bytes(c)))
                send_access(CMD_SW, ERR_NONE, RDY_OK, MEM_BASE + byte_offset(a), $urandom,
                            16'($urandom_range(0, 40)));
        end
        else if (pick <= 78)
        begin
            c = 4'($urandom);
            a = ($urandom_range(0, 1) == 0) ? TIMER_LO_ADDR : TIMER_HI_ADDR;
        end
        else if (pick <= 84)
        begin
            case ($urandom_range(0, 2))
                0:       c = CMD_SW;
                1:       c = CMD_SH;
                default: c = CMD_SB;
            endcase
            a = UART_ADDR;
        end
        else if (pick <= 92)
        begin
            // suppressed: error set, or not ready
            c = 4'($urandom);
            e = 2'($urandom);
            r = (e == ERR_NONE) ? 2'($urandom_range(0, 2)) : 2'($urandom);
            if ($urandom_range(0, 3) == 0)
                a = ($urandom_range(0, 1) == 0) ? TIMER_LO_ADDR : UART_ADDR;
        end
        else
        begin
            c = ($urandom_range(0, 7) == 0) ? CMD_NONE
                                            : 4'($urandom_range(CMD_PASS_MIN, CMD_PASS_MAX));
            a = $urandom;
        end
        send_access(c, e, r, a, d, us);
    endtask

    // Every width, sign and zero extension, misaligned lanes
    task automatic test_lanes_and_extension();
        send_access(CMD_SW,  ERR_NONE, RDY_OK, MEM_BASE,        32'hdead_beef, 16'd0);
        send_access(CMD_LW,  ERR_NONE, RDY_OK, MEM_BASE,        32'h0,         16'd1);
        send_access(CMD_LB,  ERR_NONE, RDY_OK, MEM_BASE + 3,    32'h0,         16'd2);
        send_access(CMD_LBU, ERR_NONE, RDY_OK, MEM_BASE + 3,    32'h0,         16'd3);
        send_access(CMD_LH,  ERR_NONE, RDY_OK, MEM_BASE + 2,    32'h0,         16'd4);
        send_access(CMD_LHU, ERR_NONE, RDY_OK, MEM_BASE + 2,    32'h0,         16'd5);
        send_access(CMD_SW,  ERR_NONE, RDY_OK, MEM_BASE + 4,    32'h1234_5678, 16'd6);
        send_access(CMD_LB,  ERR_NONE, RDY_OK, MEM_BASE + 4,    32'h0,         16'd7);
        send_access(CMD_LH,  ERR_NONE, RDY_OK, MEM_BASE + 5,    32'h0,         16'd8);
        send_access(CMD_SH,  ERR_NONE, RDY_OK, MEM_BASE + 1,    32'hffff_8001, 16'd9);
        send_access(CMD_SB,  ERR_NONE, RDY_OK, MEM_BASE + 3,    32'h0000_007f, 16'd10);
        send_access(CMD_LW,  ERR_NONE, RDY_OK, MEM_BASE + 1,    32'h0,         16'd11);
    endtask

    // Word that straddles the top of memory, read back through aliases
    task automatic test_wraparound_and_aliases();
        send_access(CMD_SW, ERR_NONE, RDY_OK, MEM_BASE + MEM_BYTES - 2, 32'ha1b2_c3d4, 16'd0);
        send_access(CMD_LW, ERR_NONE, RDY_OK, 32'hffff_fffe,            32'h0,         16'd0);
        send_access(CMD_LH, ERR_NONE, RDY_OK, 32'h0000_0000,            32'h0,         16'd0);
    endtask

    // Both timer words; a store to the timer writes nothing
    task automatic test_timer_words();
        send_access(CMD_LW,  ERR_NONE, RDY_OK, TIMER_LO_ADDR, 32'h0,         16'hffff);
        send_access(CMD_LBU, ERR_NONE, RDY_OK, TIMER_HI_ADDR, 32'h0,         16'hffff);
        send_access(CMD_SW,  ERR_NONE, RDY_OK, TIMER_LO_ADDR, 32'hffff_ffff, 16'd1);
    endtask

    task automatic test_uart_port();
        send_access(CMD_SB, ERR_NONE, RDY_OK, UART_ADDR, 32'h0000_0041, 16'd2);
        send_access(CMD_SW, ERR_NONE, RDY_OK, UART_ADDR, 32'hffff_ffff, 16'd2);
    endtask

    // Error or not-ready accesses return zero and leave memory and UART alone
    task automatic test_suppressed_access();
        send_access(CMD_SW, 2'd3,     RDY_OK, MEM_BASE,  32'h0,         16'd1);
        send_access(CMD_LW, ERR_NONE, 2'd0,   MEM_BASE,  32'h0,         16'd1);
        send_access(CMD_SB, 2'd1,     RDY_OK, UART_ADDR, 32'h0000_0055, 16'd1);
        send_access(CMD_LW, ERR_NONE, RDY_OK, MEM_BASE,  32'h0,         16'd1);
    endtask

    task automatic test_address_passthrough();
        send_access(CMD_NONE,     ERR_NONE, RDY_OK, 32'hffff_ffff, 32'hffff_ffff, 16'd0);
        send_access(CMD_PASS_MAX, ERR_NONE, RDY_OK, 32'h0000_0000, 32'h0,         16'd0);
    endtask

    // Random traffic with the sender idle before idle_pct percent of the items
    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned items);
        for (int unsigned i = 0; i < items; i++)
        begin
            if ($urandom_range(1, 100) <= idle_pct)
                idle_cycles($urandom_range(1, 4));
            // now and then let every outstanding result come back first
            if (i % 50 == 49)
                wait_drain();
            send_random_access();
        end
        wait_drain();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_lanes_and_extension();
        test_wraparound_and_aliases();
        test_timer_words();
        test_uart_port();
        test_suppressed_access();
        test_address_passthrough();
        wait_drain();

        test_random_traffic(0, 160);
        test_random_traffic(66, 160);
        test_random_traffic(34, 170);

        idle_cycles(TAIL_CYCLES);
        if (expected_results.size() != 0)
        begin
            $error("%0d results never arrived", expected_results.size());
            check_failures++;
        end
        if (check_failures == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lsm_pkg.sv
rtl/load_store_memory_with_mmio_top.sv
verif/testbench.sv
